// ----- sv/frustum_cull_tester_macros.svh -----
// assertion macros shared by the checker
`ifndef FRUSTUM_CULL_TESTER_MACROS_SVH
`define FRUSTUM_CULL_TESTER_MACROS_SVH

// same-cycle implication
`define FCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frustum cull check failed");

// next-cycle implication
`define FCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum cull check failed");

`endif

// ----- sv/fct_pkg.sv -----
package fct_pkg;

  localparam int NUM_PLANES_DEF = 6;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_SPHERE = 2'd2;
  localparam logic [1:0] KIND_BOX    = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         plane_index;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] scalar;
  } in_word_t;

  typedef struct packed {
    logic       visible;
    logic [1:0] test_kind;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
  } plane_t;

endpackage

// ----- sv/frustum_cull_tester.sv -----
// Frustum cull tester. A load word (kind 0) writes one plane (a, b, c, d) of a
// table of NUM_PLANES planes held in a synchronous memory; it gives no result,
// and a slot at or above NUM_PLANES is ignored. Planes read as zero until
// loaded. A test word (point, sphere or box) gives one result word with the
// visible flag and the echoed kind. One plane is read from the table per
// cycle into a registered read stage, then the multiply stage registers the
// products and the corner sum stage updates the running flags; after the last
// plane the result is posted to the output register once it is free. The input
// takes no new word until the result of a test has been posted. All eight box
// corners are tested against a plane in the same cycle from six shared products.
// The input accepts the next word while an earlier result still waits on the
// output.
module frustum_cull_tester #(
  parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fct_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output fct_pkg::out_word_t out_word
);
  import fct_pkg::*;

  localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // plane table and its loaded flags
  plane_t mem [NUM_PLANES];
  logic   ent_v_r [NUM_PLANES];

  in_word_t item_r;
  logic [IDX_W-1:0] rd_cnt_r, rd_cnt_nxt;

  // pipeline: memory read, products, corner sums
  plane_t rdata_r;
  logic   rent_v_r;
  logic   s1_v_r, s1_last_r;
  logic   s2_v_r, s2_last_r;
  logic signed [63:0] pxl_r, pxh_r, pyl_r, pyh_r, pzl_r, pzh_r;
  logic signed [32:0] dr_r;

  // running flags over planes
  logic [7:0] all_pos_r;
  logic       box_fail_r;
  logic       sph_fail_r;

  out_word_t out_r;
  logic      out_v_r;

  logic accept, is_load, wr_en, issue, last_issue;
  logic [7:0] neg, pos;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_load   = (in_word.kind == KIND_LOAD);
  assign wr_en     = accept && is_load && ({29'd0, in_word.plane_index} < NUM_PLANES);
  assign issue     = (state_r == ST_RUN);
  assign last_issue = (rd_cnt_r == IDX_W'(NUM_PLANES - 1));

  // table write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_word.plane_index[IDX_W-1:0]] <= '{a: in_word.first_x, b: in_word.first_y,
                                               c: in_word.first_z, d: in_word.scalar};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) ent_v_r[i] <= 1'b0;
    end else if (wr_en) begin
      ent_v_r[in_word.plane_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  // table read port, registered
  always_ff @(posedge clk) begin
    rdata_r  <= mem[rd_cnt_r];
    rent_v_r <= ent_v_r[rd_cnt_r];
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        rd_cnt_nxt = '0;
        if (accept && !is_load) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (last_issue) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (s2_v_r && s2_last_r) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_v_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_cnt_r  <= '0;
      s1_v_r    <= 1'b0;
      s1_last_r <= 1'b0;
      s2_v_r    <= 1'b0;
      s2_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      s1_v_r    <= issue;
      s1_last_r <= issue && last_issue;
      s2_v_r    <= s1_v_r;
      s2_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_load) item_r <= in_word;
  end

  // product stage: both bounds per axis cover all eight corners
  plane_t pl;
  logic signed [32:0] extra;
  assign pl    = rent_v_r ? rdata_r : '0;
  assign extra = (item_r.kind == KIND_SPHERE) ? 33'(item_r.scalar) : 33'sd0;

  always_ff @(posedge clk) begin
    pxl_r <= pl.a * item_r.first_x;
    pxh_r <= pl.a * item_r.second_x;
    pyl_r <= pl.b * item_r.first_y;
    pyh_r <= pl.b * item_r.second_y;
    pzl_r <= pl.c * item_r.first_z;
    pzh_r <= pl.c * item_r.second_z;
    dr_r  <= 33'(pl.d) + extra;
  end

  // corner sums, exact in 67 bits
  always_comb begin
    logic signed [66:0] sum;
    for (int k = 0; k < 8; k++) begin
      sum = 67'(((k & 1) != 0) ? pxh_r : pxl_r)
          + 67'(((k & 2) != 0) ? pyh_r : pyl_r)
          + 67'(((k & 4) != 0) ? pzh_r : pzl_r)
          + (67'(dr_r) <<< 16);
      neg[k] = sum[66];
      pos[k] = !sum[66] && (sum != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_load) begin
      all_pos_r  <= '1;
      box_fail_r <= 1'b0;
      sph_fail_r <= 1'b0;
    end else if (s2_v_r) begin
      all_pos_r  <= all_pos_r & pos;
      box_fail_r <= box_fail_r | (&neg);
      sph_fail_r <= sph_fail_r | neg[0];
    end
  end

  // output register, parts the two sides
  logic vis;
  always_comb begin
    unique case (item_r.kind)
      KIND_POINT:  vis = all_pos_r[0];
      KIND_SPHERE: vis = !sph_fail_r;
      default:     vis = (|all_pos_r) || !box_fail_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (state_r == ST_FIN && (!out_v_r || out_ready)) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && (!out_v_r || out_ready)) begin
      out_r <= '{visible: vis, test_kind: item_r.kind};
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule

// ----- sv/fct_checker.sv -----
`include "frustum_cull_tester_macros.svh"

module fct_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input fct_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_ready,
  input fct_pkg::out_word_t out_word
);
  import fct_pkg::*;

  `FCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FCT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word))
  `FCT_ASSERT_NOW(a_no_load_echo, out_valid, out_word.test_kind != KIND_LOAD)
  `FCT_ASSERT_NEXT(a_test_busy, in_valid && in_ready && in_word.kind != KIND_LOAD, !in_ready)

endmodule

bind frustum_cull_tester fct_checker u_fct_checker (.*);
